@@ rtl/prl_pkg.sv @@
`default_nettype none
package prl_pkg;

  // Default sizes of the stores.
  localparam int PrlNodeDepth   = 4096;
  localparam int PrlLeafDepth   = 65536;
  localparam int PrlHopBits     = 8;
  localparam int PrlLevels      = 8;
  localparam int PrlDirectDepth = 65536;

  // Widest index and hop that any legal parameter value needs.
  localparam int NodeIdxMaxW = 16;
  localparam int LeafIdxMaxW = 20;
  localparam int HopMaxW     = 16;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_DIRECT = 2'd1,
    OP_NODE   = 2'd2,
    OP_LEAF   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    TK_NODE = 2'd0,
    TK_LEAF = 2'd1,
    TK_DONE = 2'd2
  } tok_kind_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [2:0]  level;
    logic [15:0] entry_address;
    logic [63:0] node_vector;
    logic [63:0] node_leaf_vector;
    logic [11:0] node_child_base;
    logic [15:0] node_leaf_base;
    logic [7:0]  hop_value;
    logic [11:0] direct_child_value;
  } prl_in_t;

  typedef struct packed {
    logic [7:0] next_hop;
    logic       from_table;
  } prl_out_t;

  // One trie node as held in a level's store.
  typedef struct packed {
    logic [63:0] vec;
    logic [63:0] leaf_vec;
    logic [11:0] child_base;
    logic [15:0] leaf_base;
  } prl_node_t;

  // Lookup token handed from cell to cell.
  typedef struct packed {
    logic                   valid;
    tok_kind_e              kind;
    logic [NodeIdxMaxW-1:0] node_idx;
    logic [LeafIdxMaxW-1:0] leaf_idx;
    logic [7:0]             hop;
    logic                   found;
    logic [63:0]            key;
  } prl_tok_t;

endpackage
`default_nettype wire

@@ rtl/poptrie_route_lookup_core.sv @@
`default_nettype none
// Lookup path: once start is taken the key reads the direct table, then the token
// passes the eight level cells in order and the leaf store is read at the end.
// No new item is taken while a lookup is in flight; a table write gives no result.
// Reset: once rst_ni is released the direct table is cleared one entry a cycle,
// all 65536 entries, with busy high; trie and leaf stores are not cleared.
// Results cannot be stalled by the receiver.
module poptrie_route_lookup_core #(
  parameter int NodeDepth = prl_pkg::PrlNodeDepth,
  parameter int LeafDepth = prl_pkg::PrlLeafDepth,
  parameter int HopBits   = prl_pkg::PrlHopBits
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire prl_pkg::prl_in_t  item_i,
  output logic                   res_valid_o,
  output prl_pkg::prl_out_t      res_o,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_data_i
);
  import prl_pkg::*;

  localparam int NodeAw   = $clog2(NodeDepth);
  localparam int LeafAw   = $clog2(LeafDepth);
  localparam int DirAw    = $clog2(PrlDirectDepth);
  localparam int DirW     = HopBits + 12;

  logic             accept;
  logic [7:0]       dflt_q;
  logic             clr_q;
  logic [DirAw-1:0] clr_cnt_q;
  logic             pend_q;
  prl_tok_t         tok0_q;
  prl_tok_t         dir_tok;
  prl_tok_t         chain [PrlLevels+1];
  prl_tok_t         end_q;
  logic             dir_we;
  logic [DirAw-1:0] dir_waddr;
  logic [DirW-1:0]  dir_wdata;
  logic [DirW-1:0]  dir_rdata;
  logic [HopBits-1:0] hop_wr;
  logic [HopBits-1:0] dir_hop;
  logic [HopBits-1:0] leaf_rdata;
  logic [11:0]      dir_child;
  logic [31:0]      wide;
  logic [31:0]      leaf_wide;
  logic [31:0]      wr_wide;
  prl_node_t        wr_node;

  assign accept = start && !busy;
  assign busy   = clr_q || pend_q;

  assign wr_wide = 32'(item_i.hop_value);
  assign hop_wr  = wr_wide[HopBits-1:0];

  // Direct table: clearing pass after reset, then writes by command.
  always_comb begin
    if (clr_q) begin
      dir_we    = 1'b1;
      dir_waddr = clr_cnt_q;
      dir_wdata = '0;
    end else begin
      dir_we    = accept && item_i.opcode == OP_DIRECT;
      dir_waddr = item_i.entry_address[DirAw-1:0];
      dir_wdata = {hop_wr, item_i.direct_child_value};
    end
  end

  prl_ram #(.Width(DirW), .Depth(PrlDirectDepth)) u_direct (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (item_i.key[63:48]),
    .rdata_o (dir_rdata)
  );

  // Control: default register, clearing counter, lookup in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q    <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
      tok0_q    <= '0;
      end_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        dflt_q <= cfg_data_i;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          clr_q <= 1'b0;
        end
      end
      if (accept && item_i.opcode == OP_LOOKUP) begin
        pend_q <= 1'b1;
      end else if (end_q.valid) begin
        pend_q <= 1'b0;
      end
      tok0_q <= '{valid: accept && item_i.opcode == OP_LOOKUP, kind: TK_NODE,
                  node_idx: '0, leaf_idx: '0, hop: '0, found: 1'b0,
                  key: item_i.key};
      end_q  <= chain[PrlLevels];
    end
  end

  // Resolve the direct entry into a node request or a finished answer.
  always_comb begin
    dir_hop   = dir_rdata[DirW-1:12];
    dir_child = dir_rdata[11:0];
    wide      = 32'(dir_hop);
    dir_tok   = tok0_q;
    if (dir_hop != '0) begin
      dir_tok.kind  = TK_DONE;
      dir_tok.hop   = wide[7:0];
      dir_tok.found = 1'b1;
    end else if (dir_child != '0) begin
      dir_tok.kind     = TK_NODE;
      dir_tok.node_idx = '0;
      dir_tok.node_idx[NodeAw-1:0] = NodeAw'(32'(dir_child) & 32'(NodeDepth - 1));
    end else begin
      dir_tok.kind  = TK_DONE;
      dir_tok.hop   = dflt_q;
      dir_tok.found = 1'b0;
    end
  end

  assign chain[0] = dir_tok;

  assign wr_node.vec        = item_i.node_vector;
  assign wr_node.leaf_vec   = item_i.node_leaf_vector;
  assign wr_node.child_base = item_i.node_child_base;
  assign wr_node.leaf_base  = item_i.node_leaf_base;

  // Row of level cells, one per stride.
  for (genvar g = 0; g < PrlLevels; g++) begin : g_cell
    prl_level_cell #(.Level(g), .NodeDepth(NodeDepth)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain[g]),
      .tok_o     (chain[g+1]),
      .wr_en_i   (accept && item_i.opcode == OP_NODE && item_i.level == 3'(g)),
      .wr_addr_i (item_i.entry_address[NodeAw-1:0]),
      .wr_node_i (wr_node)
    );
  end

  // Leaf store, read by the token leaving the last cell.
  prl_ram #(.Width(HopBits), .Depth(LeafDepth)) u_leaf (
    .clk_i   (clk_i),
    .we_i    (accept && item_i.opcode == OP_LEAF),
    .waddr_i (LeafAw'(32'(item_i.entry_address) & 32'(LeafDepth - 1))),
    .wdata_i (hop_wr),
    .raddr_i (chain[PrlLevels].leaf_idx[LeafAw-1:0]),
    .rdata_o (leaf_rdata)
  );

  // Result transfer.
  assign leaf_wide   = 32'(leaf_rdata);
  assign res_valid_o = end_q.valid;
  always_comb begin
    if (end_q.kind == TK_LEAF) begin
      res_o.next_hop   = leaf_wide[7:0];
      res_o.from_table = 1'b1;
    end else begin
      res_o.next_hop   = end_q.hop;
      res_o.from_table = end_q.found;
    end
  end

endmodule
`default_nettype wire

@@ rtl/prl_ram.sv @@
`default_nettype none
module prl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ rtl/prl_level_cell.sv @@
`default_nettype none
module prl_level_cell #(
  parameter int Level     = 0,
  parameter int NodeDepth = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire prl_pkg::prl_tok_t                tok_i,
  output prl_pkg::prl_tok_t                     tok_o,
  input  wire logic                             wr_en_i,
  input  wire logic [$clog2(NodeDepth)-1:0]     wr_addr_i,
  input  wire prl_pkg::prl_node_t               wr_node_i
);
  import prl_pkg::*;

  localparam int AddrW   = $clog2(NodeDepth);
  localparam int ChunkLo = 42 - 6 * Level;
  localparam bit IsLast  = (Level == PrlLevels - 1);

  prl_tok_t  tok_q;
  prl_node_t node;
  logic [5:0]  chunk;
  logic [63:0] upto;
  logic [31:0] child_sum;
  logic [31:0] leaf_sum;

  // Node store of this level, read at the index the token carries.
  prl_ram #(.Width($bits(prl_node_t)), .Depth(NodeDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_node_i),
    .raddr_i (tok_i.node_idx[AddrW-1:0]),
    .rdata_o (node)
  );

  // The token waits here while the node is read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // Step one level down, or turn into a leaf request.
  always_comb begin
    chunk     = tok_q.key[ChunkLo +: 6];
    upto      = (64'd2 << chunk) - 64'd1;
    child_sum = 32'(node.child_base) + 32'($countones(node.vec & upto));
    leaf_sum  = 32'(node.leaf_base) + 32'($countones(node.leaf_vec & upto));
    tok_o     = tok_q;
    if (tok_q.valid && tok_q.kind == TK_NODE) begin
      if (!IsLast && node.vec[chunk]) begin
        tok_o.node_idx             = '0;
        tok_o.node_idx[AddrW-1:0]  = child_sum[AddrW-1:0];
      end else begin
        tok_o.kind     = TK_LEAF;
        tok_o.leaf_idx = leaf_sum[LeafIdxMaxW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ sim/poptrie_route_lookup_core_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module poptrie_route_lookup_core_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire prl_pkg::prl_in_t item_i,
  input  wire logic             res_valid_o,
  input  wire prl_pkg::prl_out_t res_o,
  input  wire logic             cfg_we_i,
  input  wire logic [7:0]       cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_routes_o
);
  import prl_pkg::*;

  localparam int NodeDepth = PrlNodeDepth;
  localparam int LeafDepth = PrlLeafDepth;

  // Shadow copy of the route tables and the default hop.
  bit [7:0]   shadow_direct_hop   [PrlDirectDepth];
  bit [11:0]  shadow_direct_child [PrlDirectDepth];
  prl_node_t  shadow_nodes        [int];
  bit [7:0]   shadow_leaf_hop     [LeafDepth];
  logic [7:0] shadow_default_hop;

  prl_out_t expected_routes[$];

  // Walks the trie for one key, as the block should.
  function automatic prl_out_t predict_route(input logic [63:0] key);
    prl_out_t  route;
    int        top;
    int        idx;
    int        leaf_idx;
    logic [5:0] chunk;
    logic [63:0] upto;
    prl_node_t nd;
    route.next_hop   = shadow_default_hop;
    route.from_table = 1'b0;
    top = int'(key[63:48]);
    if (shadow_direct_hop[top] != 8'd0) begin
      route.next_hop   = shadow_direct_hop[top];
      route.from_table = 1'b1;
    end else if (shadow_direct_child[top] != 12'd0) begin
      idx = int'(shadow_direct_child[top]) % NodeDepth;
      for (int lvl = 0; lvl < PrlLevels; lvl++) begin
        chunk = key[47 - 6 * lvl -: 6];
        upto  = (64'd2 << chunk) - 64'd1;
        nd    = shadow_nodes[lvl * NodeDepth + idx];
        if (lvl < PrlLevels - 1 && nd.vec[chunk]) begin
          idx = (int'(nd.child_base) + $countones(nd.vec & upto)) % NodeDepth;
        end else begin
          leaf_idx = (int'(nd.leaf_base) + $countones(nd.leaf_vec & upto)) % LeafDepth;
          route.next_hop   = shadow_leaf_hop[leaf_idx];
          route.from_table = 1'b1;
          break;
        end
      end
    end
    return route;
  endfunction

  // Table updates, predictions and result comparison, all sampled at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    prl_out_t exp_route;
    if (!rst_ni) begin
      shadow_default_hop = 8'd0;
      mismatch_count_o   = 0;
      pending_routes_o   = 0;
      expected_routes.delete();
    end else begin
      if (cfg_we_i) begin
        shadow_default_hop = cfg_data_i;
      end
      if (start && !busy) begin
        case (opcode_e'(item_i.opcode))
          OP_DIRECT: begin
            shadow_direct_hop[item_i.entry_address]   = item_i.hop_value;
            shadow_direct_child[item_i.entry_address] = item_i.direct_child_value;
          end
          OP_NODE: begin
            shadow_nodes[int'(item_i.level) * NodeDepth
                         + int'(item_i.entry_address) % NodeDepth] =
              '{vec: item_i.node_vector, leaf_vec: item_i.node_leaf_vector,
                child_base: item_i.node_child_base, leaf_base: item_i.node_leaf_base};
          end
          OP_LEAF: begin
            shadow_leaf_hop[int'(item_i.entry_address) % LeafDepth] = item_i.hop_value;
          end
          default: begin
            expected_routes.push_back(predict_route(item_i.key));
          end
        endcase
      end
      if (res_valid_o) begin
        if (expected_routes.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("unexpected route result: hop %0d from_table %0b",
                     res_o.next_hop, res_o.from_table);
          end
        end else begin
          exp_route = expected_routes.pop_front();
          if (res_o.next_hop !== exp_route.next_hop ||
              res_o.from_table !== exp_route.from_table) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("route mismatch: expected hop %0d from_table %0b, got hop %0d from_table %0b",
                       exp_route.next_hop, exp_route.from_table,
                       res_o.next_hop, res_o.from_table);
            end
          end
        end
      end
      pending_routes_o = expected_routes.size();
    end
  end

endmodule
`default_nettype wire

@@ sim/poptrie_route_lookup_core_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module poptrie_route_lookup_core_tb;
  import prl_pkg::*;

  localparam int IdleLimit   = 200000;
  localparam int DrainCycles = 20;
  localparam int PhaseItems  = 130;
  localparam int SafeNodes   = 96;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  prl_in_t  item_i;
  logic     res_valid_o;
  prl_out_t res_o;
  logic     cfg_we_i;
  logic [7:0] cfg_data_i;
  int       mismatch_count;
  int       pending_routes;
  int       idle_cycles;

  logic [15:0] hot_tops[32];

  poptrie_route_lookup_core dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_valid_o, .res_o, .cfg_we_i, .cfg_data_i
  );

  poptrie_route_lookup_core_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_valid_o, .res_o, .cfg_we_i, .cfg_data_i,
    .mismatch_count_o(mismatch_count), .pending_routes_o(pending_routes)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is abandoned when nothing is transferred for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("poptrie_route_lookup_core_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Unused fields carry noise so that every bit moves.
  function automatic prl_in_t noise_item(input opcode_e op);
    prl_in_t it;
    logic [287:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    it = raw[$bits(prl_in_t)-1:0];
    it.opcode = op;
    return it;
  endfunction

  // Bases whose children and leaves land in the pre-loaded region, wrap included.
  function automatic logic [11:0] safe_child_base();
    return ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, SafeNodes - 65))
                                      : 12'd4095;
  endfunction

  function automatic logic [15:0] safe_leaf_base();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 63))
                                      : 16'($urandom_range(65472, 65535));
  endfunction

  function automatic prl_in_t node_item(input logic [2:0] lvl, input logic [15:0] addr,
                                        input logic [63:0] vec, input logic [63:0] lvec,
                                        input logic [11:0] cb, input logic [15:0] lb);
    prl_in_t it;
    it = noise_item(OP_NODE);
    it.level = lvl;
    it.entry_address = addr;
    it.node_vector = vec;
    it.node_leaf_vector = lvec;
    it.node_child_base = cb;
    it.node_leaf_base = lb;
    return it;
  endfunction

  function automatic prl_in_t leaf_item(input logic [15:0] addr, input logic [7:0] hop);
    prl_in_t it;
    it = noise_item(OP_LEAF);
    it.entry_address = addr;
    it.hop_value = hop;
    return it;
  endfunction

  // A zero hop only ever points at a root inside the pre-loaded region.
  function automatic prl_in_t direct_item(input logic [15:0] addr, input logic [7:0] hop,
                                          input logic [11:0] child);
    prl_in_t it;
    it = noise_item(OP_DIRECT);
    it.entry_address = addr;
    it.hop_value = hop;
    it.direct_child_value = child;
    return it;
  endfunction

  function automatic prl_in_t lookup_item(input logic [63:0] key);
    prl_in_t it;
    it = noise_item(OP_LOOKUP);
    it.key = key;
    return it;
  endfunction

  // Key with the same stride chunk at every level.
  function automatic logic [63:0] chunk_key(input logic [15:0] top, input logic [5:0] chunk);
    logic [63:0] key;
    key = {top, 48'd0};
    for (int lvl = 0; lvl < PrlLevels; lvl++) begin
      key[47 - 6 * lvl -: 6] = chunk;
    end
    return key;
  endfunction

  function automatic prl_in_t random_item();
    int sel;
    logic [15:0] addr;
    logic [7:0] hop;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      return lookup_item(($urandom_range(0, 9) < 7) ? {hot_tops[$urandom_range(0, 31)],
                                                      48'(rand64())}
                                                    : rand64());
    end else if (sel < 70) begin
      addr = ($urandom_range(0, 9) < 6) ? hot_tops[$urandom_range(0, 31)] : 16'($urandom);
      hop = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom);
      if (hop == 8'd0) begin
        return direct_item(addr, hop, ($urandom_range(0, 9) == 0) ? 12'd0
                                     : 12'($urandom_range(1, SafeNodes - 1)));
      end
      return direct_item(addr, hop, 12'($urandom));
    end else if (sel < 85) begin
      addr = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, SafeNodes - 1)
                                             | ($urandom_range(0, 15) << 12))
                                        : 16'($urandom);
      return node_item(3'($urandom), addr, rand64(), rand64(),
                       safe_child_base(), safe_leaf_base());
    end
    return leaf_item(16'($urandom), 8'($urandom));
  endfunction

  // One transfer; start stays high so a burst can continue at the next edge.
  task automatic send(input prl_in_t it);
    logic taken;
    start  <= 1'b1;
    item_i <= it;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits for every route result and for busy to fall, then idles before going on.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_routes != 0 || busy);
    @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_default_hop(input logic [7:0] hop);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= hop;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < items; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 9) >= 3) pause($urandom_range(1, 15));
      end
      send(random_item());
      burst_left--;
    end
  endtask

  initial begin
    logic [7:0] phase_hops[4];
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_data_i = 8'd0;
    phase_hops = '{8'hFF, 8'h00, 8'h5A, 8'($urandom)};
    for (int n = 0; n < 32; n++) hot_tops[n] = 16'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    write_default_hop(phase_hops[0]);

    // Pre-load every node and leaf that a safe base or root can reach.
    for (int lvl = 0; lvl < PrlLevels; lvl++) begin
      for (int idx = 0; idx < SafeNodes; idx++) begin
        send(node_item(3'(lvl), 16'(idx), rand64(), rand64(),
                       safe_child_base(), safe_leaf_base()));
      end
    end
    for (int idx = 0; idx < 128; idx++) send(leaf_item(16'(idx), 8'($urandom)));
    for (int idx = 65472; idx < 65536; idx++) send(leaf_item(16'(idx), 8'($urandom)));

    // Directed lookups: direct hit, default, full-depth walk with wrapping bases,
    // an early leaf on the last chunk, a zero leaf hop and a hop beating a child.
    for (int lvl = 0; lvl < PrlLevels; lvl++) begin
      send(node_item(3'(lvl), 16'd1, '1, '1, 12'd4095, 16'd65535));
    end
    send(node_item(3'd0, 16'd2, 64'd0, '1, 12'd0, 16'd65472));
    send(leaf_item(16'd0, 8'd0));
    send(leaf_item(16'd1, 8'hFF));
    send(direct_item(16'h1234, 8'd0, 12'd1));
    send(direct_item(16'hFFFF, 8'hFF, 12'd4095));
    send(direct_item(16'h0000, 8'd0, 12'd2));
    send(direct_item(16'h8000, 8'h01, 12'd1));
    send(lookup_item(chunk_key(16'h1234, 6'd1)));
    send(lookup_item(64'hFFFF_FFFF_FFFF_FFFF));
    send(lookup_item(chunk_key(16'h0000, 6'd63)));
    send(lookup_item(chunk_key(16'h8000, 6'd0)));
    send(lookup_item(64'h4321_0000_0000_0000));
    send(lookup_item(chunk_key(16'h1234, 6'd0)));
    send(leaf_item(16'd1, 8'd0));
    send(lookup_item(chunk_key(16'h1234, 6'd1)));

    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        drain();
        write_default_hop(phase_hops[ph]);
      end
      random_phase(PhaseItems);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("poptrie_route_lookup_core_tb: done, clean");
    end else begin
      $display("poptrie_route_lookup_core_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/prl_pkg.sv
rtl/prl_ram.sv
rtl/prl_level_cell.sv
rtl/poptrie_route_lookup_core.sv
sim/poptrie_route_lookup_core_checker.sv
sim/poptrie_route_lookup_core_tb.sv
